@@ design/pct_pkg.sv @@
`default_nettype none
package pct_pkg;

    localparam int PCT_MAX_NODES  = 4096;
    localparam int PCT_ALPHABET   = 26;
    localparam int PCT_COUNT_BITS = 16;

    localparam int LETTER_W    = 5;
    localparam int SUM_W       = 32;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LINK,
        S_COUNT,
        S_DONE
    } t_pct_state;

    typedef struct packed {
        logic clear_step;
        logic take;
        logic link_eval;
        logic count_eval;
        logic emit;
    } t_pct_cmd;

    typedef struct packed {
        logic clr_done;
        logic item_go;
        logic link_go;
        logic item_last;
        logic out_free;
    } t_pct_sts;

endpackage
`default_nettype wire

@@ design/pct_ram.sv @@
`default_nettype none
module pct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ design/pct_ctrl.sv @@
`default_nettype none
module pct_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire pct_pkg::t_pct_sts i_sts,
    output pct_pkg::t_pct_cmd      o_cmd
);
    import pct_pkg::*;

    t_pct_state r_state;
    t_pct_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = i_sts.item_go ? S_LINK : S_DONE;
                end
            end
            S_LINK: begin
                o_cmd.link_eval = 1'b1;
                n_state         = i_sts.link_go ? S_COUNT : S_DONE;
            end
            S_COUNT: begin
                o_cmd.count_eval = 1'b1;
                n_state          = i_sts.item_last ? S_DONE : S_IDLE;
            end
            S_DONE: begin
                // hold a finished string until the output register has room
                if (!i_sts.item_last) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ design/pct_dpath.sv @@
`default_nettype none
module pct_dpath #(
    parameter int MAX_NODES  = pct_pkg::PCT_MAX_NODES,
    parameter int ALPHABET   = pct_pkg::PCT_ALPHABET,
    parameter int COUNT_BITS = pct_pkg::PCT_COUNT_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire pct_pkg::t_pct_cmd            i_cmd,
    output pct_pkg::t_pct_sts                 o_sts,
    input  wire logic                         i_action,
    input  wire logic [pct_pkg::LETTER_W-1:0] i_letter,
    input  wire logic                         i_last,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [pct_pkg::SUM_W-1:0]         o_sum_value,
    output logic                              o_status,
    output logic                              o_was_query
);
    import pct_pkg::*;

    localparam int SLOTS  = MAX_NODES * ALPHABET;
    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int FREE_W = $clog2(MAX_NODES + 1);

    logic [NODE_W-1:0]     r_cursor;
    logic [SLOT_W-1:0]     r_row_base;
    logic [SLOT_W-1:0]     r_slot;
    logic [SUM_W-1:0]      r_sum;
    logic                  r_stopped;
    logic                  r_full;
    logic [FREE_W-1:0]     r_next_free;
    logic                  r_action;
    logic                  r_last;
    logic [SLOT_W-1:0]     r_clr_addr;
    logic                  r_out_valid;
    logic [SUM_W-1:0]      r_out_sum;
    logic                  r_out_status;
    logic                  r_out_query;

    logic [SLOT_W-1:0]     slot_addr;
    logic [NODE_W-1:0]     link_rd;
    logic                  link_hit;
    logic                  table_full;
    logic                  link_go;
    logic [NODE_W-1:0]     child;
    logic [COUNT_BITS-1:0] count_rd;
    logic [COUNT_BITS-1:0] count_inc;
    logic [SUM_W:0]        sum_ext;
    logic [SUM_W-1:0]      sum_sat;
    logic                  item_go;
    logic                  out_free;

    logic                  link_we;
    logic [SLOT_W-1:0]     link_waddr;
    logic [NODE_W-1:0]     link_wdata;
    logic                  count_we;
    logic [NODE_W-1:0]     count_waddr;
    logic [COUNT_BITS-1:0] count_wdata;

    assign slot_addr  = r_row_base + SLOT_W'(i_letter);
    assign item_go    = !r_stopped && (int'(i_letter) < ALPHABET);
    assign link_hit   = (link_rd != '0) && (int'(link_rd) < MAX_NODES);
    assign table_full = int'(r_next_free) >= MAX_NODES;
    assign link_go    = link_hit || (!r_action && !table_full);
    assign child      = link_hit ? link_rd : r_next_free[NODE_W-1:0];
    assign count_inc  = (count_rd == {COUNT_BITS{1'b1}}) ? count_rd
                                                        : count_rd + 1'b1;
    assign sum_ext    = {1'b0, r_sum} + (SUM_W + 1)'(count_rd);
    assign sum_sat    = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        link_we     = i_cmd.clear_step || (i_cmd.link_eval && link_go && !link_hit);
        link_waddr  = i_cmd.clear_step ? r_clr_addr : r_slot;
        link_wdata  = i_cmd.clear_step ? '0 : r_next_free[NODE_W-1:0];
        count_we    = (i_cmd.clear_step && (int'(r_clr_addr) < MAX_NODES))
                   || (i_cmd.count_eval && !r_action);
        count_waddr = i_cmd.clear_step ? r_clr_addr[NODE_W-1:0] : r_cursor;
        count_wdata = i_cmd.clear_step ? '0 : count_inc;
    end

    pct_ram #(
        .WIDTH (NODE_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (slot_addr),
        .o_rdata (link_rd)
    );

    pct_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_NODES)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (count_we),
        .i_waddr (count_waddr),
        .i_wdata (count_wdata),
        .i_raddr (child),
        .o_rdata (count_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_row_base  <= '0;
            r_sum       <= '0;
            r_stopped   <= 1'b0;
            r_full      <= 1'b0;
            r_next_free <= FREE_W'(1);
            r_action    <= 1'b0;
            r_last      <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end

            if (i_cmd.take) begin
                r_action <= i_action;
                r_last   <= i_last;
                r_slot   <= slot_addr;
                if (!item_go) begin
                    r_stopped <= 1'b1;
                end
            end

            if (i_cmd.link_eval) begin
                if (link_go) begin
                    r_cursor <= child;
                    if (!link_hit) begin
                        r_next_free <= r_next_free + 1'b1;
                    end
                end else begin
                    r_stopped <= 1'b1;
                    // an insert only fails here when no node is left
                    if (!r_action) begin
                        r_full <= 1'b1;
                    end
                end
            end

            if (i_cmd.count_eval) begin
                r_row_base <= SLOT_W'(r_cursor) * SLOT_W'(ALPHABET);
                if (r_action) begin
                    r_sum <= sum_sat;
                end
            end

            if (i_cmd.emit) begin
                r_out_valid  <= 1'b1;
                r_out_sum    <= r_action ? r_sum : '0;
                r_out_status <= !r_action && r_full;
                r_out_query  <= r_action;
                // restart the walk at the root
                r_cursor     <= '0;
                r_row_base   <= '0;
                r_sum        <= '0;
                r_stopped    <= 1'b0;
                r_full       <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.clr_done  = (r_clr_addr == SLOT_W'(SLOTS - 1));
        o_sts.item_go   = item_go;
        o_sts.link_go   = link_go;
        o_sts.item_last = r_last;
        o_sts.out_free  = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_sum_value = r_out_sum;
    assign o_status    = r_out_status;
    assign o_was_query = r_out_query;

endmodule
`default_nettype wire

@@ design/prefix_count_trie.sv @@
`default_nettype none
// Counting prefix trie. Each item on the slave stream is one letter (a = 0 .. z = 25) with
// tuser = 1 for query and 0 for insert, and tlast on the final letter of a string; one result
// item leaves on the master stream for each tlast letter. Steps: a letter is accepted, its
// link-memory entry is read, then its count is read and updated; the final letter then also
// loads the output register. A letter out of range, or one that meets a stopped walk, goes
// from acceptance straight to the done state, final letter included. A letter whose link is
// missing on a query, or on an insert into a full table, goes to the done state after the
// link read. The steps follow the chain link read -> count read -> count write over the
// single-port-read memories. A full result register holds the block on the final letter until
// the result is taken. After reset the block sweeps the link and count memories to zero with s_axis_tready low.
module prefix_count_trie #(
    parameter int MAX_NODES  = pct_pkg::PCT_MAX_NODES,
    parameter int ALPHABET   = pct_pkg::PCT_ALPHABET,
    parameter int COUNT_BITS = pct_pkg::PCT_COUNT_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [pct_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [4:0] letter
    input  wire logic                            s_axis_tuser,  // action
    input  wire logic                            s_axis_tlast,  // last
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [pct_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // [31:0] sum_value, [32] status
    output logic                                 m_axis_tuser   // was_query
);
    import pct_pkg::*;

    t_pct_cmd           cmd;
    t_pct_sts           sts;
    logic [SUM_W-1:0]   sum_value;
    logic               status;

    pct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pct_dpath #(
        .MAX_NODES  (MAX_NODES),
        .ALPHABET   (ALPHABET),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_action    (s_axis_tuser),
        .i_letter    (s_axis_tdata[LETTER_W-1:0]),
        .i_last      (s_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_sum_value (sum_value),
        .o_status    (status),
        .o_was_query (m_axis_tuser)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - SUM_W - 1){1'b0}}, status, sum_value};

endmodule
`default_nettype wire
